// ----- hw/rtl/rlst_pkg.sv -----
// shared types, codes and the acquire decision for the recursive lock stack tracker
// no dependencies; used by rlst_ctrl, rlst_stack_mem and recursive_lock_stack_tracker
package rlst_pkg;

  localparam int DEF_STACK_DEPTH = 32;
  localparam int DEF_ID_BITS     = 16;
  localparam int LOCK_ID_W       = 16;

  localparam logic [2:0] OP_ACQ_RD = 3'd0;
  localparam logic [2:0] OP_TRY_RD = 3'd1;
  localparam logic [2:0] OP_REL_RD = 3'd2;
  localparam logic [2:0] OP_ACQ_WR = 3'd3;
  localparam logic [2:0] OP_TRY_WR = 3'd4;
  localparam logic [2:0] OP_REL_WR = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_WRONG   = 3'd3;
  localparam logic [2:0] ST_WAR     = 3'd4;
  localparam logic [2:0] ST_REFUSED = 3'd5;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_ACQ_RD = 3'd1;
  localparam logic [2:0] CMD_TRY_RD = 3'd2;
  localparam logic [2:0] CMD_ACQ_WR = 3'd3;
  localparam logic [2:0] CMD_TRY_WR = 3'd4;
  localparam logic [2:0] CMD_REL_RD = 3'd5;
  localparam logic [2:0] CMD_REL_WR = 3'd6;

  localparam logic [1:0] OWN_KEEP  = 2'd0;
  localparam logic [1:0] OWN_SET   = 2'd1;
  localparam logic [1:0] OWN_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_TOP_RD,
    S_TOP_CMP
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] cmd;
    logic [1:0] own;
    logic       push;
    logic       first;
  } acq_res_t;

  // outcome of an acquire once it is known whether the lock is already on the stack
  function automatic acq_res_t acq_resolve(input logic [2:0] op, input logic granted,
                                           input logic hit);
    acq_res_t r;
    logic     wr;
    logic     is_try;
    r      = '{status: ST_OK, cmd: CMD_NONE, own: OWN_KEEP, push: 1'b0, first: 1'b0};
    wr     = (op == OP_ACQ_WR) || (op == OP_TRY_WR);
    is_try = (op == OP_TRY_RD) || (op == OP_TRY_WR);
    if (hit) begin
      if (wr) begin
        r.status = ST_WAR;
      end else begin
        r.push = 1'b1;
      end
    end else if (is_try) begin
      r.cmd = wr ? CMD_TRY_WR : CMD_TRY_RD;
      if (granted) begin
        r.push  = 1'b1;
        r.first = 1'b1;
        r.own   = wr ? OWN_SET : OWN_KEEP;
      end else begin
        r.status = ST_REFUSED;
      end
    end else begin
      r.cmd   = wr ? CMD_ACQ_WR : CMD_ACQ_RD;
      r.push  = 1'b1;
      r.first = 1'b1;
      r.own   = wr ? OWN_SET : OWN_KEEP;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/rlst_stack_mem.sv -----
// lock id stack storage: one write port, one registered read port
// depends on rlst_pkg for the control struct
module rlst_stack_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int W     = 16
) (
  input  logic               clk,
  input  rlst_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [W-1:0]       wdata,
  input  logic [AW-1:0]      raddr,
  output logic [W-1:0]       rdata
);
  import rlst_pkg::*;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rlst_ctrl.sv -----
// sequencer for the lock stack: decode, linear search with one shared comparator,
// top-of-stack check, depth and release bits, result registers; uses rlst_pkg
module rlst_ctrl #(
  parameter int STACK_DEPTH = 32,
  parameter int DW          = 6,
  parameter int AW          = 5,
  parameter int SW          = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      opcode,
  input  logic [rlst_pkg::LOCK_ID_W-1:0]  lock_id,
  input  logic                            owned_by_me,
  input  logic                            try_granted,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [2:0]                      lower_command,
  output logic [1:0]                      owner_update,
  output logic [5:0]                      held_depth,
  output rlst_pkg::mem_ctl_t              mem_ctl,
  output logic [AW-1:0]                   mem_waddr,
  output logic [SW-1:0]                   mem_wdata,
  output logic [AW-1:0]                   mem_raddr,
  input  logic [SW-1:0]                   mem_rdata
);
  import rlst_pkg::*;

  localparam logic [DW-1:0] FULL_D = DW'(STACK_DEPTH);

  state_t               state, state_next;
  logic [2:0]           op_r;
  logic [SW-1:0]        id_r;
  logic                 mine_r;
  logic                 granted_r;
  logic [DW-1:0]        depth, depth_m1, depth_next;
  logic [STACK_DEPTH-1:0] rel;
  logic [DW-1:0]        scan, scan_next;
  logic                 pend, pend_next;
  logic                 id_eq;
  logic                 issue;

  logic                 fin;
  logic [2:0]           r_status;
  logic [2:0]           r_cmd;
  logic [1:0]           r_own;
  logic                 do_push, push_first, do_pop;
  acq_res_t             acq;

  assign busy      = (state != S_IDLE);
  assign depth_m1  = depth - 1'b1;
  assign id_eq     = (mem_rdata == id_r);
  assign issue     = (scan < depth);
  assign mem_waddr = depth[AW-1:0];
  assign mem_wdata = id_r;
  assign mem_raddr = (state == S_SEARCH) ? scan[AW-1:0] : depth_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    fin         = 1'b0;
    r_status    = ST_OK;
    r_cmd       = CMD_NONE;
    r_own       = OWN_KEEP;
    do_push     = 1'b0;
    push_first  = 1'b0;
    do_pop      = 1'b0;
    scan_next   = scan;
    pend_next   = 1'b0;
    mem_ctl     = '{rd_en: 1'b0, wr_en: 1'b0};
    acq         = acq_resolve(op_r, granted_r, 1'b0);
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_r) inside
          OP_ACQ_RD, OP_TRY_RD, OP_ACQ_WR, OP_TRY_WR: begin
            if (depth == FULL_D) begin
              fin        = 1'b1;
              r_status   = ST_FULL;
              state_next = S_IDLE;
            end else if (mine_r && (op_r == OP_ACQ_WR || op_r == OP_TRY_WR)) begin
              // nested write hold: push with a clear release bit
              fin        = 1'b1;
              do_push    = 1'b1;
              state_next = S_IDLE;
            end else begin
              scan_next  = '0;
              state_next = S_SEARCH;
            end
          end
          OP_REL_RD, OP_REL_WR: begin
            if (depth == '0) begin
              fin        = 1'b1;
              r_status   = ST_EMPTY;
              state_next = S_IDLE;
            end else begin
              state_next = S_TOP_RD;
            end
          end
          default: begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SEARCH: begin
        // read of slot scan is issued now, its compare happens next cycle
        mem_ctl.rd_en = issue;
        pend_next     = issue;
        if (issue) begin
          scan_next = scan + 1'b1;
        end
        if ((pend && id_eq) || (!pend && !issue)) begin
          acq        = acq_resolve(op_r, granted_r, pend && id_eq);
          fin        = 1'b1;
          r_status   = acq.status;
          r_cmd      = acq.cmd;
          r_own      = acq.own;
          do_push    = acq.push;
          push_first = acq.first;
          pend_next  = 1'b0;
          state_next = S_IDLE;
        end
      end
      S_TOP_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_next    = S_TOP_CMP;
      end
      S_TOP_CMP: begin
        fin        = 1'b1;
        state_next = S_IDLE;
        if (!id_eq) begin
          r_status = ST_WRONG;
        end else begin
          do_pop = 1'b1;
          if (rel[depth_m1[AW-1:0]]) begin
            r_cmd = (op_r == OP_REL_RD) ? CMD_REL_RD : CMD_REL_WR;
            r_own = (op_r == OP_REL_RD) ? OWN_KEEP : OWN_CLEAR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    mem_ctl.wr_en = do_push;
  end

  always_comb begin
    depth_next = depth;
    if (do_push) begin
      depth_next = depth + 1'b1;
    end else if (do_pop) begin
      depth_next = depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      rel   <= '0;
      done  <= 1'b0;
    end else begin
      depth <= depth_next;
      done  <= fin;
      if (do_push) begin
        rel[depth[AW-1:0]] <= push_first;
      end else if (do_pop) begin
        rel[depth_m1[AW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan <= scan_next;
    pend <= pend_next;
    if (start && state == S_IDLE) begin
      op_r      <= opcode;
      id_r      <= lock_id[SW-1:0];
      mine_r    <= owned_by_me;
      granted_r <= try_granted;
    end
    if (fin) begin
      status        <= r_status;
      lower_command <= r_cmd;
      owner_update  <= r_own;
      held_depth    <= 6'(depth_next);
    end
  end

endmodule

// ----- hw/rtl/recursive_lock_stack_tracker.sv -----
// top level of the recursive reader-writer lock stack tracker
// depends on rlst_pkg, rlst_stack_mem and rlst_ctrl
//
//   channel  | handshake             | word
//   ---------+-----------------------+--------------------------------------------
//   request  | start high, busy low  | opcode, lock_id, owned_by_me, try_granted
//   result   | done high, one cycle  | status, lower_command, owner_update, held_depth
//
// one request gives one result. a release reads the top slot and compares it with the
// request id. an acquire that searches the stack reads slots one at a time from slot 0
// upward, through the single stack read port feeding one comparator, and stops at the
// first hit or after the last held slot.
// full, empty, nested write and undefined requests finish in decode. busy is high
// from the cycle after accept until the result cycle; a new word may be accepted while
// done is high. reset clears the depth and release bits, the id storage is not
// cleared. the receiver cannot stall results.
module recursive_lock_stack_tracker #(
  parameter int STACK_DEPTH = rlst_pkg::DEF_STACK_DEPTH,
  parameter int ID_BITS     = rlst_pkg::DEF_ID_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     opcode,
  input  logic [rlst_pkg::LOCK_ID_W-1:0] lock_id,
  input  logic                           owned_by_me,
  input  logic                           try_granted,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [2:0]                     lower_command,
  output logic [1:0]                     owner_update,
  output logic [5:0]                     held_depth
);
  import rlst_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SW = (ID_BITS < LOCK_ID_W) ? ID_BITS : LOCK_ID_W;

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [SW-1:0] mem_wdata;
  logic [SW-1:0] mem_rdata;

  rlst_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW),
    .W     (SW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rlst_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .DW          (DW),
    .AW          (AW),
    .SW          (SW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .lock_id       (lock_id),
    .owned_by_me   (owned_by_me),
    .try_granted   (try_granted),
    .done          (done),
    .status        (status),
    .lower_command (lower_command),
    .owner_update  (owner_update),
    .held_depth    (held_depth),
    .mem_ctl       (mem_ctl),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

endmodule
